// File: rtl/core/sts_pkg.sv
// Shared types and constants of the timer slot table.
// No dependencies; every other file of the block refers to it by scoped names.
package sts_pkg;

	localparam int TASK_W   = 8;
	localparam int COUNT_W  = 16;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	// input mode
	localparam logic MODE_SET  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// result kind
	localparam logic [KIND_W-1:0] KIND_SET       = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRY    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 2'd2;

	// set status
	localparam logic [STATUS_W-1:0] ST_UPDATED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CLAIMED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	localparam logic [TASK_W-1:0]  TASK_IDLE = 8'd0;
	localparam logic [COUNT_W-1:0] COUNT_ONE = 16'd1;

	// controller to datapath
	typedef struct packed {
		logic scan;    // walking the slots, one per cycle unless the output stalls
		logic finish;  // producing the closing result of the item
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;  // last slot evaluated this cycle
		logic fin_done;   // closing result handed to the output register
	} dp_stat_t;

endpackage

// File: rtl/core/sts_ifs.sv
// Valid/ready channel interfaces of the timer slot table.
// Depends on sts_pkg for field widths.
interface sts_req_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [sts_pkg::TASK_W-1:0]   task_id;
	logic [sts_pkg::COUNT_W-1:0]  delay;

	modport source (output valid, mode, task_id, delay, input ready);
	modport sink   (input valid, mode, task_id, delay, output ready);
endinterface

interface sts_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [sts_pkg::KIND_W-1:0]    kind;
	logic [sts_pkg::TASK_W-1:0]    expired_task;
	logic [sts_pkg::STATUS_W-1:0]  set_status;
	logic                          last;

	modport source (output valid, kind, expired_task, set_status, last, input ready);
	modport sink   (input valid, kind, expired_task, set_status, last, output ready);
endinterface

// File: rtl/core/software_timer_slot_table.sv
// Timer slot table. Each slot holds a task id (0 = idle) and a 16-bit count.
// A set item refreshes the slot that holds the task, else claims the lowest
// idle slot, else reports the table full (as it does for task id 0); it gives
// one result. A tick item decrements every busy slot, expires slots at 1 and
// reports each expiry in slot order (last marks the final one), or one
// idle-tick result. Items are taken one at a time: each walks all SLOTS
// entries of the slot memory through its single read port, one slot per
// cycle unless the result side stalls. Reset clears the busy bits at once; no
// clearing pass is needed.
module software_timer_slot_table #(
	parameter int SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sts_req_if.sink    req,
	sts_rsp_if.source  rsp
);

	sts_pkg::ctl_cmd_t cmd;
	sts_pkg::dp_stat_t stat;
	logic              in_ready;
	logic              accept;

	assign req.ready = in_ready;
	assign accept    = req.valid && in_ready;

	sts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.stat     (stat),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	sts_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (req.mode),
		.task_id      (req.task_id),
		.delay        (req.delay),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.kind         (rsp.kind),
		.expired_task (rsp.expired_task),
		.set_status   (rsp.set_status),
		.last         (rsp.last)
	);

	// one item in flight: no new item right after an accept
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("item accepted while another is in flight");

	// only expiries may be followed by more results of the same item
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.kind != sts_pkg::KIND_EXPIRY)) |-> rsp.last)
		else $error("non-expiry result without last");

	// an idle slot never expires
	a_expiry_task: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.kind == sts_pkg::KIND_EXPIRY)) |->
			(rsp.expired_task != sts_pkg::TASK_IDLE))
		else $error("expiry reported for idle task id");

endmodule

// File: rtl/core/sts_ctrl.sv
// Controller of the timer slot table: idle / scan / finish sequencing.
// Depends on sts_pkg for the command and status structs.
module sts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  sts_pkg::dp_stat_t stat,
	output sts_pkg::ctl_cmd_t cmd,
	output logic              in_ready
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t            state_q;
	sts_pkg::ctl_cmd_t cmd_q;
	logic              ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q     <= S_SCAN;
						ready_q     <= 1'b0;
						cmd_q.scan  <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.scan_done) begin
						state_q       <= S_FINISH;
						cmd_q.scan    <= 1'b0;
						cmd_q.finish  <= 1'b1;
					end
				end
				S_FINISH: begin
					if (stat.fin_done) begin
						state_q       <= S_IDLE;
						cmd_q.finish  <= 1'b0;
						ready_q       <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					cmd_q   <= '0;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign cmd      = cmd_q;
	assign in_ready = ready_q;

endmodule

// File: rtl/core/sts_datapath.sv
// Datapath of the timer slot table: slot memory, busy bits, scan pipeline,
// pending expiry and the output register. Depends on sts_pkg.
module sts_datapath #(
	parameter int SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  sts_pkg::ctl_cmd_t             cmd,
	output sts_pkg::dp_stat_t             stat,
	input  logic                          mode,
	input  logic [sts_pkg::TASK_W-1:0]    task_id,
	input  logic [sts_pkg::COUNT_W-1:0]   delay,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sts_pkg::KIND_W-1:0]    kind,
	output logic [sts_pkg::TASK_W-1:0]    expired_task,
	output logic [sts_pkg::STATUS_W-1:0]  set_status,
	output logic                          last
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(SLOTS);

	// slot storage; a slot's entry is meaningful only while its busy bit is set
	logic [sts_pkg::TASK_W-1:0]  mem_task  [SLOTS];
	logic [sts_pkg::COUNT_W-1:0] mem_count [SLOTS];
	logic [SLOTS-1:0]            busy_q;

	// captured item
	logic                         mode_q;
	logic [sts_pkg::TASK_W-1:0]   task_q;
	logic [sts_pkg::COUNT_W-1:0]  delay_q;

	// scan pipeline: read issue, then evaluate on registered read data
	logic [CNT_W-1:0]             rd_cnt_q;
	logic                         eval_vld_q;
	logic [IDX_W-1:0]             eval_idx_q;
	logic [sts_pkg::TASK_W-1:0]   rd_task_q;
	logic [sts_pkg::COUNT_W-1:0]  rd_count_q;

	logic                         hit_q;
	logic [IDX_W-1:0]             hit_idx_q;
	logic                         free_q;
	logic [IDX_W-1:0]             free_idx_q;
	logic                         pend_q;
	logic [sts_pkg::TASK_W-1:0]   pend_task_q;

	logic                         out_vld_q;
	logic [sts_pkg::KIND_W-1:0]   kind_q;
	logic [sts_pkg::TASK_W-1:0]   exp_task_q;
	logic [sts_pkg::STATUS_W-1:0] status_q;
	logic                         last_q;

	logic                         out_free;
	logic                         eval_busy;
	logic                         eval_now;
	logic                         tick_exp;
	logic                         push_mid;
	logic                         stall;
	logic                         adv;
	logic                         issue;
	logic [IDX_W-1:0]             rd_idx;
	logic                         fin_push;
	logic                         set_reject;
	logic                         fin_hit;
	logic                         fin_claim;

	logic                         wr_count_en;
	logic                         wr_task_en;
	logic [IDX_W-1:0]             wr_idx;
	logic [sts_pkg::COUNT_W-1:0]  wr_count;

	assign out_free  = !out_vld_q || out_ready;
	assign rd_idx    = rd_cnt_q[IDX_W-1:0];
	assign issue     = rd_cnt_q < SLOTS_C;
	assign eval_busy = busy_q[eval_idx_q];

	// an expiry while one is already pending pushes the older one out (last = 0)
	assign tick_exp  = cmd.scan && eval_vld_q && (mode_q == sts_pkg::MODE_TICK)
		&& eval_busy && (rd_count_q == sts_pkg::COUNT_ONE);
	assign push_mid  = tick_exp && pend_q;
	assign stall     = push_mid && !out_free;
	assign adv       = cmd.scan && !stall;
	assign eval_now  = adv && eval_vld_q;

	assign fin_push   = cmd.finish && out_free;
	assign set_reject = (task_q == sts_pkg::TASK_IDLE);
	assign fin_hit    = !set_reject && hit_q;
	assign fin_claim  = !set_reject && !hit_q && free_q;

	assign stat.scan_done = eval_now && (eval_idx_q == LAST_IDX);
	assign stat.fin_done  = fin_push;

	always_comb begin
		wr_count_en = 1'b0;
		wr_task_en  = 1'b0;
		wr_idx      = eval_idx_q;
		wr_count    = sts_pkg::COUNT_W'(rd_count_q - sts_pkg::COUNT_ONE);
		if (eval_now && (mode_q == sts_pkg::MODE_TICK) && eval_busy && !tick_exp) begin
			wr_count_en = 1'b1;
		end else if (fin_push && (mode_q == sts_pkg::MODE_SET)) begin
			wr_count = delay_q;
			if (fin_hit) begin
				wr_count_en = 1'b1;
				wr_idx      = hit_idx_q;
			end else if (fin_claim) begin
				wr_count_en = 1'b1;
				wr_task_en  = 1'b1;
				wr_idx      = free_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_count_en) begin
			mem_count[wr_idx] <= wr_count;
		end
		if (wr_task_en) begin
			mem_task[wr_idx] <= task_q;
		end
		if (adv && issue) begin
			rd_task_q  <= mem_task[rd_idx];
			rd_count_q <= mem_count[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mode_q  <= mode;
			task_q  <= task_id;
			delay_q <= delay;
		end
		if (eval_now) begin
			eval_idx_q <= rd_idx;
		end else if (adv) begin
			eval_idx_q <= rd_idx;
		end
		if (eval_now && (mode_q == sts_pkg::MODE_SET)) begin
			if (eval_busy && (rd_task_q == task_q)) begin
				hit_idx_q <= eval_idx_q;
			end
			if (!eval_busy && !free_q) begin
				free_idx_q <= eval_idx_q;
			end
		end
		if (eval_now && tick_exp) begin
			pend_task_q <= rd_task_q;
		end
		if (eval_now && push_mid) begin
			kind_q     <= sts_pkg::KIND_EXPIRY;
			exp_task_q <= pend_task_q;
			status_q   <= sts_pkg::ST_UPDATED;
			last_q     <= 1'b0;
		end else if (fin_push) begin
			last_q <= 1'b1;
			if (mode_q == sts_pkg::MODE_SET) begin
				kind_q     <= sts_pkg::KIND_SET;
				exp_task_q <= sts_pkg::TASK_IDLE;
				if (fin_hit) begin
					status_q <= sts_pkg::ST_UPDATED;
				end else if (fin_claim) begin
					status_q <= sts_pkg::ST_CLAIMED;
				end else begin
					status_q <= sts_pkg::ST_FULL;
				end
			end else if (pend_q) begin
				kind_q     <= sts_pkg::KIND_EXPIRY;
				exp_task_q <= pend_task_q;
				status_q   <= sts_pkg::ST_UPDATED;
			end else begin
				kind_q     <= sts_pkg::KIND_IDLE_TICK;
				exp_task_q <= sts_pkg::TASK_IDLE;
				status_q   <= sts_pkg::ST_UPDATED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			rd_cnt_q   <= '0;
			eval_vld_q <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			pend_q     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (load) begin
				rd_cnt_q   <= '0;
				eval_vld_q <= 1'b0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
				pend_q     <= 1'b0;
			end else if (adv) begin
				eval_vld_q <= issue;
				if (issue) begin
					rd_cnt_q <= CNT_W'(rd_cnt_q + 1'b1);
				end
			end
			if (eval_now && (mode_q == sts_pkg::MODE_SET)) begin
				if (eval_busy && (rd_task_q == task_q)) begin
					hit_q <= 1'b1;
				end
				if (!eval_busy) begin
					free_q <= 1'b1;
				end
			end
			if (eval_now && tick_exp) begin
				busy_q[eval_idx_q] <= 1'b0;
				pend_q             <= 1'b1;
			end
			if (fin_push && (mode_q == sts_pkg::MODE_SET) && fin_claim) begin
				busy_q[free_idx_q] <= 1'b1;
			end
			if ((eval_now && push_mid) || fin_push) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_vld_q;
	assign kind         = kind_q;
	assign expired_task = exp_task_q;
	assign set_status   = status_q;
	assign last         = last_q;

endmodule

// File: bench/tb_software_timer_slot_table.sv
`timescale 1ns / 100ps
// Testbench of software_timer_slot_table: directed and random set/tick items are
// checked against a slot-table predictor, with random stalls on both channels.
// Depends on sts_pkg, sts_ifs and the block's RTL.
module tb_software_timer_slot_table;

	localparam int SLOTS        = 16;
	localparam int RANDOM_ITEMS = 320;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 2 * (SLOTS + 3);
	localparam int PRINT_CAP    = 60;

	typedef struct packed {
		logic                        mode;
		logic [sts_pkg::TASK_W-1:0]  task_id;
		logic [sts_pkg::COUNT_W-1:0] delay;
	} timer_req_t;

	typedef struct packed {
		logic [sts_pkg::KIND_W-1:0]   kind;
		logic [sts_pkg::TASK_W-1:0]   expired_task;
		logic [sts_pkg::STATUS_W-1:0] set_status;
		logic                         last;
	} timer_rsp_t;

	logic clk;
	logic arst_n;

	sts_req_if req_ch ();
	sts_rsp_if rsp_ch ();

	software_timer_slot_table #(.SLOTS(SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	timer_req_t queued_requests[$];
	timer_rsp_t due_results[$];
	timer_req_t next_req;

	logic [sts_pkg::TASK_W-1:0]  table_task [SLOTS] = '{default: sts_pkg::TASK_IDLE};
	logic [sts_pkg::COUNT_W-1:0] table_count[SLOTS] = '{default: '0};

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count = 0;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Mirror of the slot table; queues every result the item will cause.
	function automatic void predict_timers(timer_req_t it);
		timer_rsp_t held;
		bit have_held;
		bit found;
		held = '0;
		have_held = 1'b0;
		found = 1'b0;
		if (it.mode == sts_pkg::MODE_SET) begin
			held.kind = sts_pkg::KIND_SET;
			held.last = 1'b1;
			held.set_status = sts_pkg::ST_FULL;
			if (it.task_id != sts_pkg::TASK_IDLE) begin
				for (int i = 0; i < SLOTS; i++)
					if (!found && table_task[i] == it.task_id) begin
						table_count[i] = it.delay;
						held.set_status = sts_pkg::ST_UPDATED;
						found = 1'b1;
					end
				for (int i = 0; i < SLOTS; i++)
					if (!found && table_task[i] == sts_pkg::TASK_IDLE) begin
						table_task[i] = it.task_id;
						table_count[i] = it.delay;
						held.set_status = sts_pkg::ST_CLAIMED;
						found = 1'b1;
					end
			end
			due_results.insert(due_results.size(), held);
		end else begin
			// each expiry is held back one step so the final one can carry last
			for (int i = 0; i < SLOTS; i++)
				if (table_task[i] != sts_pkg::TASK_IDLE) begin
					if (table_count[i] != sts_pkg::COUNT_ONE) begin
						table_count[i] = table_count[i] - sts_pkg::COUNT_ONE;
					end else begin
						if (have_held)
							due_results.insert(due_results.size(), held);
						held = '0;
						held.kind = sts_pkg::KIND_EXPIRY;
						held.expired_task = table_task[i];
						have_held = 1'b1;
						table_task[i] = sts_pkg::TASK_IDLE;
					end
				end
			if (!have_held) begin
				held = '0;
				held.kind = sts_pkg::KIND_IDLE_TICK;
			end
			held.last = 1'b1;
			due_results.insert(due_results.size(), held);
		end
	endfunction

	task automatic check_result(timer_rsp_t got);
		timer_rsp_t want;
		if (due_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind=%0d task=%0d status=%0d last=%0d",
				got.kind, got.expired_task, got.set_status, got.last));
		end else begin
			want = due_results[0];
			due_results.delete(0);
			if (got.kind !== want.kind)
				report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.expired_task !== want.expired_task)
				report_mismatch($sformatf("expired_task %0d, want %0d",
					got.expired_task, want.expired_task));
			if (got.set_status !== want.set_status)
				report_mismatch($sformatf("set_status %0d, want %0d",
					got.set_status, want.set_status));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
		end
	endtask

	function automatic timer_req_t random_request();
		timer_req_t it;
		int pick;
		it.mode = sts_pkg::MODE_SET;
		it.task_id = sts_pkg::TASK_W'($urandom);
		it.delay = sts_pkg::COUNT_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 40) begin
			it.mode = sts_pkg::MODE_TICK;
		end else if (pick < 44) begin
			it.task_id = sts_pkg::TASK_IDLE;
		end else if (pick < 52) begin
			// stray task ids get short delays so they do not clog the table
			it.delay = sts_pkg::COUNT_W'($urandom_range(1, 4));
		end else begin
			it.task_id = sts_pkg::TASK_W'($urandom_range(1, 24));
			pick = $urandom_range(99);
			if (pick < 70)
				it.delay = sts_pkg::COUNT_W'($urandom_range(1, 5));
			else if (pick < 88)
				it.delay = sts_pkg::COUNT_W'($urandom_range(0, 20));
		end
		return it;
	endfunction

	task automatic add_request(logic mode, int task_id, int delay);
		timer_req_t it;
		it.mode = mode;
		it.task_id = sts_pkg::TASK_W'(task_id);
		it.delay = sts_pkg::COUNT_W'(delay);
		queued_requests.insert(queued_requests.size(), it);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.mode    <= sts_pkg::MODE_SET;
			req_ch.task_id <= '0;
			req_ch.delay   <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_timers('{req_ch.mode, req_ch.task_id, req_ch.delay});
			if (!req_ch.valid || req_ch.ready) begin
				if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = queued_requests[0];
					queued_requests.delete(0);
					req_ch.valid   <= 1'b1;
					req_ch.mode    <= next_req.mode;
					req_ch.task_id <= next_req.task_id;
					req_ch.delay   <= next_req.delay;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_result('{rsp_ch.kind, rsp_ch.expired_task, rsp_ch.set_status,
					rsp_ch.last});
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL software_timer_slot_table");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		send_idle_pct = 21;
		recv_idle_pct = 68;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_request(sts_pkg::MODE_TICK, 255, 65535);   // tick on an empty table
		add_request(sts_pkg::MODE_SET, 0, 7);          // idle id is rejected
		add_request(sts_pkg::MODE_SET, 255, 1);
		add_request(sts_pkg::MODE_SET, 255, 2);        // refresh
		add_request(sts_pkg::MODE_SET, 1, 0);          // zero delay wraps at tick
		add_request(sts_pkg::MODE_SET, 22, 65535);
		add_request(sts_pkg::MODE_TICK, 0, 0);
		add_request(sts_pkg::MODE_TICK, 0, 0);         // 255 expires
		add_request(sts_pkg::MODE_SET, 20, 16'h5555);  // reclaims the lowest idle slot
		add_request(sts_pkg::MODE_SET, 21, 16'hAAAA);
		for (int t = 2; t < 14; t++)
			add_request(sts_pkg::MODE_SET, t, 1);
		add_request(sts_pkg::MODE_SET, 14, 3);         // table full
		add_request(sts_pkg::MODE_TICK, 0, 0);         // burst of expiries
		add_request(sts_pkg::MODE_SET, 1, 1);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 21;
					recv_idle_pct = 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 21;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (RANDOM_ITEMS / 3)
				queued_requests.insert(queued_requests.size(), random_request());
			while (queued_requests.size() != 0 || req_ch.valid || due_results.size() != 0)
				@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS software_timer_slot_table");
		else
			$display("FAIL software_timer_slot_table");
		$finish;
	end

endmodule
